/* rtl/core/wrrtp_pkg.sv */
// Shared types, constants and helper functions of the weighted round-robin task picker.
package wrrtp_pkg;

    localparam int SLOTS = 16;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SLOT_EXT_W = (IDX_W > 4) ? IDX_W : 4;

    localparam int IN_DATA_W  = 88;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 16;

    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_LOAD   = 2'd1,
        MODE_SETCUR = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    localparam logic [1:0] ST_OTHER   = 2'd0;
    localparam logic [1:0] ST_RUN     = 2'd1;
    localparam logic [1:0] ST_BLOCKED = 2'd2;
    localparam logic [1:0] ST_ZOMBIE  = 2'd3;

    localparam logic [4:0] WOKEN_MAX = 5'd31;

    typedef struct packed {
        logic [3:0]  pad;
        logic        preempt_held;
        logic [31:0] now_tick;
        logic        slot_managed;
        logic        slot_own_space;
        logic        slot_is_idle;
        logic        slot_has_context;
        logic [7:0]  slot_weight;
        logic [31:0] slot_wake_tick;
        logic        slot_occupied;
        logic [1:0]  slot_state;
        logic [3:0]  slot;
    } t_item;

    typedef struct packed {
        logic [3:0] pad;
        logic [4:0] woken_count;
        logic       uses_own_space;
        logic       new_turn;
        logic       chosen_valid;
        logic [3:0] chosen_slot;
    } t_result;

    typedef struct packed {
        logic [1:0]  state;
        logic        occupied;
        logic [31:0] deadline;
        logic [7:0]  weight;
        logic [7:0]  quantum;
        logic        has_context;
        logic        is_idle;
        logic        own_space;
        logic        managed;
    } t_entry;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_LOAD    = 8'b0000_0010,
        S_SETCUR  = 8'b0000_0100,
        S_WAKE    = 8'b0000_1000,
        S_CHECK   = 8'b0001_0000,
        S_SCAN    = 8'b0010_0000,
        S_REFRESH = 8'b0100_0000,
        S_REPORT  = 8'b1000_0000
    } t_state;

    typedef struct packed {
        logic capture;
        logic load;
        logic setcur;
        logic wake;
        logic check;
        logic scan;
        logic refresh;
        logic report;
    } t_cmd;

    typedef struct packed {
        t_mode in_mode;
        logic  wake_last;
        logic  gate;
        logic  keep;
        logic  hit;
        logic  scan_last;
        logic  out_free;
    } t_sts;

    function automatic logic [7:0] turn_len(input t_entry e);
        return (e.weight != 8'd0) ? e.weight : 8'd1;
    endfunction

    function automatic logic eligible(input t_entry e);
        return e.occupied && (e.state == ST_RUN) && !e.is_idle && e.has_context
            && !(e.own_space && !e.managed);
    endfunction

endpackage

/* rtl/core/wrrtp_ctrl.sv */
// Picker FSM: steps an item via load, setcur, wake, check, scan, refresh and report.
module wrrtp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  wrrtp_pkg::t_sts  i_sts,
    output wrrtp_pkg::t_cmd  o_cmd
);
    import wrrtp_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    unique case (i_sts.in_mode)
                        MODE_TICK:   n_state = S_WAKE;
                        MODE_LOAD:   n_state = S_LOAD;
                        MODE_SETCUR: n_state = S_SETCUR;
                        MODE_NONE:   n_state = S_REPORT;
                        default:     n_state = S_REPORT;
                    endcase
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_REPORT;
            end
            S_SETCUR: begin
                o_cmd.setcur = 1'b1;
                n_state      = S_REPORT;
            end
            S_WAKE: begin
                o_cmd.wake = 1'b1;
                if (i_sts.wake_last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                if (!i_sts.gate || i_sts.keep) begin
                    n_state = S_REPORT;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.hit) begin
                    n_state = S_REPORT;
                end else if (i_sts.scan_last) begin
                    n_state = S_REFRESH;
                end
            end
            S_REFRESH: begin
                o_cmd.refresh = 1'b1;
                n_state       = S_REPORT;
            end
            S_REPORT: begin
                o_cmd.report = 1'b1;
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

/* rtl/core/wrrtp_dpath.sv */
// Datapath of the task picker: slot table, scan pointer, current slot and result register.
module wrrtp_dpath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [wrrtp_pkg::IN_DATA_W-1:0]   i_in_data,
    input  logic [wrrtp_pkg::IN_USER_W-1:0]   i_in_user,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_data,
    input  wrrtp_pkg::t_cmd                   i_cmd,
    output wrrtp_pkg::t_sts                   o_sts,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [wrrtp_pkg::OUT_DATA_W-1:0]  o_out_data
);
    import wrrtp_pkg::*;

    t_entry                r_tab [SLOTS];
    t_item                 r_item;
    logic                  r_sched;
    logic [IDX_W-1:0]      r_idx;
    logic [IDX_W-1:0]      r_cnt;
    logic [IDX_W-1:0]      r_cur;
    logic [4:0]            r_woken;
    logic                  r_new_turn;
    logic                  r_cur_run;
    logic [7:0]            r_cur_turn;
    logic                  r_out_valid;
    t_result               r_out;

    t_item                 in_item;
    t_entry                rd;
    t_entry                ld_entry;
    t_entry                wk_entry;
    t_result               res_next;
    logic [SLOT_EXT_W-1:0] slot_ext;
    logic [SLOT_EXT_W-1:0] cur_ext;
    logic [IDX_W-1:0]      slot_idx;
    logic                  slot_in_rng;
    logic [IDX_W-1:0]      idx_next;
    logic [IDX_W-1:0]      cur_next;
    logic [31:0]           diff;
    logic                  due;
    logic                  gate;
    logic                  keep;
    logic                  hit;
    logic                  idx_last;
    logic                  out_free;

    assign in_item     = t_item'(i_in_data);
    assign rd          = r_tab[r_idx];
    assign slot_ext    = SLOT_EXT_W'(r_item.slot);
    assign slot_idx    = slot_ext[IDX_W-1:0];
    assign slot_in_rng = (32'(r_item.slot) < 32'(SLOTS));
    assign cur_ext     = SLOT_EXT_W'(r_cur);
    assign idx_last    = (r_idx == IDX_W'(SLOTS - 1));
    assign idx_next    = idx_last ? '0 : r_idx + 1'b1;
    assign cur_next    = (r_cur == IDX_W'(SLOTS - 1)) ? '0 : r_cur + 1'b1;
    assign diff        = r_item.now_tick - rd.deadline;
    assign due         = rd.occupied && (rd.state == ST_BLOCKED) && (rd.deadline != 32'd0)
                         && !diff[31];
    assign gate        = r_sched && !r_item.preempt_held && rd.occupied;
    assign keep        = (rd.state == ST_RUN) && (rd.quantum > 8'd1);
    assign hit         = eligible(rd);
    assign out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        ld_entry             = '0;
        ld_entry.state       = r_item.slot_state;
        ld_entry.occupied    = r_item.slot_occupied;
        ld_entry.deadline    = r_item.slot_wake_tick;
        ld_entry.weight      = r_item.slot_weight;
        ld_entry.quantum     = 8'd0;
        ld_entry.has_context = r_item.slot_has_context;
        ld_entry.is_idle     = r_item.slot_is_idle;
        ld_entry.own_space   = r_item.slot_own_space;
        ld_entry.managed     = r_item.slot_managed;
    end

    always_comb begin
        wk_entry          = rd;
        wk_entry.state    = ST_RUN;
        wk_entry.deadline = 32'd0;
    end

    always_comb begin
        res_next                = '0;
        res_next.chosen_slot    = cur_ext[3:0];
        res_next.chosen_valid   = rd.occupied;
        res_next.new_turn       = r_new_turn;
        res_next.uses_own_space = rd.occupied && rd.own_space;
        res_next.woken_count    = r_woken;
    end

    always_comb begin
        o_sts           = '0;
        o_sts.in_mode   = t_mode'(i_in_user);
        o_sts.wake_last = idx_last;
        o_sts.gate      = gate;
        o_sts.keep      = keep;
        o_sts.hit       = hit;
        o_sts.scan_last = (r_cnt == IDX_W'(SLOTS - 1));
        o_sts.out_free  = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_tab[i] <= '0;
            end
        end else begin
            if (i_cmd.load && slot_in_rng) begin
                r_tab[slot_idx] <= ld_entry;
            end else if (i_cmd.wake && due) begin
                r_tab[r_idx] <= wk_entry;
            end else if (i_cmd.check && gate && keep) begin
                r_tab[r_idx].quantum <= rd.quantum - 8'd1;
            end else if (i_cmd.scan && hit) begin
                r_tab[r_idx].quantum <= turn_len(rd);
            end else if (i_cmd.refresh && r_cur_run) begin
                r_tab[r_idx].quantum <= r_cur_turn;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sched     <= 1'b0;
            r_cur       <= '0;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_woken     <= '0;
            r_new_turn  <= 1'b0;
            r_cur_run   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_sched <= i_cfg_data;
            end
            if (i_cmd.capture) begin
                r_woken    <= '0;
                r_new_turn <= 1'b0;
                r_idx      <= (t_mode'(i_in_user) == MODE_TICK) ? '0 : r_cur;
            end
            if (i_cmd.setcur && slot_in_rng) begin
                r_cur <= slot_idx;
                r_idx <= slot_idx;
            end
            if (i_cmd.wake) begin
                if (due && (r_woken != WOKEN_MAX)) begin
                    r_woken <= r_woken + 5'd1;
                end
                r_idx <= idx_last ? r_cur : idx_next;
            end
            if (i_cmd.check && gate && !keep) begin
                r_cur_run  <= (rd.state == ST_RUN);
                r_cur_turn <= turn_len(rd);
                r_idx      <= cur_next;
                r_cnt      <= '0;
            end
            if (i_cmd.scan) begin
                if (hit) begin
                    r_cur      <= r_idx;
                    r_new_turn <= 1'b1;
                end else if (r_cnt != IDX_W'(SLOTS - 1)) begin
                    r_idx <= idx_next;
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            if (i_cmd.report && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= in_item;
        end
        if (i_cmd.report && out_free) begin
            r_out <= res_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* rtl/core/weighted_round_robin_task_picker_core.sv */
// Top level of the weighted round-robin task picker.
//
// Channels: s_axis carries one item per transfer, tuser = mode (tick, load slot,
// set current slot), tdata = slot fields, now_tick and preempt_held. m_axis
// returns one result per item. i_cfg_valid/o_cfg_ready write the
// scheduling-enable bit; write it only while no item is in flight.
// An unused mode goes straight to the report step; a load or set-current item
// does its table or pointer write first. A tick walks a wake pass, a check of the
// current slot and, where the picker moves on, a round-robin scan. Both passes use the
// single read port of the slot table: the wake pass visits every slot, one per
// cycle, and the round-robin scan visits up to SLOTS slots, one per cycle.
// One item is worked on at a time; the next input transfer can be taken in the cycle
// after the result is written to the output register.
// A synchronous reset clears the slot table, the current slot and the enable bit.
// While the receiver stalls, the result holds in the output register; the
// next item is accepted and worked, and waits in its report step until the
// register is taken.
module weighted_round_robin_task_picker_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // slot, slot_state, slot_occupied, slot_wake_tick, slot_weight, slot_has_context,
    // slot_is_idle, slot_own_space, slot_managed, now_tick, preempt_held, zero fill
    input  logic [wrrtp_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // mode
    input  logic [wrrtp_pkg::IN_USER_W-1:0]   s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // chosen_slot, chosen_valid, new_turn, uses_own_space, woken_count, zero fill
    output logic [wrrtp_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic                              i_cfg_data
);
    import wrrtp_pkg::*;

    t_cmd cmd;
    t_sts sts;

    wrrtp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    wrrtp_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

    assign o_cfg_ready = 1'b1;

endmodule

/* rtl/core/wrrtp_checker.sv */
// Port-level checker of the task picker and its bind to the top level.
module wrrtp_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic [wrrtp_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  logic [wrrtp_pkg::IN_USER_W-1:0]   s_axis_tuser,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [wrrtp_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic                              i_cfg_valid,
    input  logic                              o_cfg_ready,
    input  logic                              i_cfg_data
);
    import wrrtp_pkg::*;

    t_result res;
    assign res = t_result'(m_axis_tdata);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken in the cycle after a transfer");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_own_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && res.uses_own_space |-> res.chosen_valid)
        else $error("own space reported for an empty slot");

    a_turn_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && res.new_turn |-> res.chosen_valid)
        else $error("new turn reported for an empty slot");

endmodule

bind weighted_round_robin_task_picker_core wrrtp_checker u_wrrtp_checker (.*);

/* tb/sv/testbench.sv */
// Testbench of the weighted round-robin task picker: directed and random items checked against a predictor.
module testbench;
    import wrrtp_pkg::*;

    localparam int          LIMIT  = 800_000;
    localparam logic [3:0]  F_CTX  = 4'b0001;
    localparam logic [3:0]  F_IDLE = 4'b0010;
    localparam logic [3:0]  F_OWN  = 4'b0100;
    localparam logic [3:0]  F_MGD  = 4'b1000;

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;
    logic [IN_USER_W-1:0]   s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic                   i_cfg_data    = 1'b0;

    logic [1:0]  tbl_state    [SLOTS];
    logic        tbl_occupied [SLOTS];
    logic [31:0] tbl_deadline [SLOTS];
    logic [7:0]  tbl_weight   [SLOTS];
    logic [7:0]  tbl_quantum  [SLOTS];
    logic        tbl_ctx      [SLOTS];
    logic        tbl_idle     [SLOTS];
    logic        tbl_own      [SLOTS];
    logic        tbl_managed  [SLOTS];
    logic [3:0]  cur_slot;
    logic        sched_en;

    t_result     expected_picks[$];
    int          err_count   = 0;
    int          cycle_count = 0;
    bit          idle_on     = 1'b1;
    int          rx_hold_req = 0;
    int          rx_stall    = 0;
    logic [31:0] now_base    = '0;

    weighted_round_robin_task_picker_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [7:0] turn_of(input int s);
        return (tbl_weight[s] != 8'd0) ? tbl_weight[s] : 8'd1;
    endfunction

    function automatic t_result next_pick(input t_mode m, input t_item it);
        t_result     r;
        int          woken;
        int          idx;
        logic [31:0] diff;
        logic        picked;
        logic [3:0]  c;
        r      = '0;
        woken  = 0;
        picked = 1'b0;
        case (m)
            MODE_LOAD: begin
                if (int'(it.slot) < SLOTS) begin
                    tbl_state[it.slot]    = it.slot_state;
                    tbl_occupied[it.slot] = it.slot_occupied;
                    tbl_deadline[it.slot] = it.slot_wake_tick;
                    tbl_weight[it.slot]   = it.slot_weight;
                    tbl_quantum[it.slot]  = 8'd0;
                    tbl_ctx[it.slot]      = it.slot_has_context;
                    tbl_idle[it.slot]     = it.slot_is_idle;
                    tbl_own[it.slot]      = it.slot_own_space;
                    tbl_managed[it.slot]  = it.slot_managed;
                end
            end
            MODE_SETCUR: begin
                if (int'(it.slot) < SLOTS) cur_slot = it.slot;
            end
            MODE_TICK: begin
                for (int i = 0; i < SLOTS; i++) begin
                    diff = it.now_tick - tbl_deadline[i];
                    if (tbl_occupied[i] && tbl_state[i] == ST_BLOCKED &&
                        tbl_deadline[i] != 32'd0 && !diff[31]) begin
                        tbl_deadline[i] = 32'd0;
                        tbl_state[i]    = ST_RUN;
                        woken++;
                    end
                end
                c = cur_slot;
                if (sched_en && !it.preempt_held && tbl_occupied[c]) begin
                    if (tbl_state[c] == ST_RUN && tbl_quantum[c] > 8'd1) begin
                        tbl_quantum[c] = tbl_quantum[c] - 8'd1;
                    end else begin
                        for (int k = 1; k <= SLOTS && !picked; k++) begin
                            idx = (int'(c) + k) % SLOTS;
                            if (tbl_occupied[idx] && tbl_state[idx] == ST_RUN &&
                                !tbl_idle[idx] && tbl_ctx[idx] &&
                                !(tbl_own[idx] && !tbl_managed[idx])) begin
                                cur_slot         = idx[3:0];
                                tbl_quantum[idx] = turn_of(idx);
                                r.new_turn       = 1'b1;
                                picked           = 1'b1;
                            end
                        end
                        if (!picked && tbl_state[c] == ST_RUN) tbl_quantum[c] = turn_of(c);
                    end
                end
            end
            default: ;
        endcase
        r.chosen_slot    = cur_slot;
        r.chosen_valid   = tbl_occupied[cur_slot];
        r.uses_own_space = tbl_occupied[cur_slot] && tbl_own[cur_slot];
        r.woken_count    = (woken > 31) ? WOKEN_MAX : woken[4:0];
        return r;
    endfunction

    function automatic t_item load_item(input logic [3:0] s, input logic [1:0] st,
                                        input logic occ, input logic [31:0] wake,
                                        input logic [7:0] w, input logic [3:0] fl);
        t_item it;
        it                  = '0;
        it.slot             = s;
        it.slot_state       = st;
        it.slot_occupied    = occ;
        it.slot_wake_tick   = wake;
        it.slot_weight      = w;
        it.slot_has_context = fl[0];
        it.slot_is_idle     = fl[1];
        it.slot_own_space   = fl[2];
        it.slot_managed     = fl[3];
        return it;
    endfunction

    function automatic t_item tick_item(input logic [31:0] now, input logic held);
        t_item it;
        it              = '0;
        it.now_tick     = now;
        it.preempt_held = held;
        return it;
    endfunction

    function automatic t_item cur_item(input logic [3:0] s);
        t_item it;
        it      = '0;
        it.slot = s;
        return it;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_count < 50)
            $display("mismatch %s: got %0d want %0d (cycle %0d)", what, got, want, cycle_count);
        err_count++;
    endtask

    task automatic send_item(input t_mode m, input t_item it);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= it;
        s_axis_tuser  <= m;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_picks.push_back(next_pick(m, it));
    endtask

    task automatic drain_all();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_picks.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_scheduling(input logic en);
        drain_all();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= en;
        do @(posedge i_clk); while (!o_cfg_ready);
        sched_en = en;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // receiver: random stall bursts, plus long holds on request
    always begin
        @(negedge i_clk);
        if (rx_hold_req > 0) begin
            rx_stall    = rx_hold_req;
            rx_hold_req = 0;
        end
        if (rx_stall > 0) begin
            m_axis_tready <= 1'b0;
            rx_stall--;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            m_axis_tready <= 1'b0;
            rx_stall = $urandom_range(0, 11);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (expected_picks.size() == 0) begin
                report_mismatch("unexpected result, slot", got.chosen_slot, 0);
            end else begin
                want = expected_picks.pop_front();
                if (got.chosen_slot != want.chosen_slot)
                    report_mismatch("chosen_slot", got.chosen_slot, want.chosen_slot);
                if (got.chosen_valid != want.chosen_valid)
                    report_mismatch("chosen_valid", got.chosen_valid, want.chosen_valid);
                if (got.new_turn != want.new_turn)
                    report_mismatch("new_turn", got.new_turn, want.new_turn);
                if (got.uses_own_space != want.uses_own_space)
                    report_mismatch("uses_own_space", got.uses_own_space, want.uses_own_space);
                if (got.woken_count != want.woken_count)
                    report_mismatch("woken_count", got.woken_count, want.woken_count);
            end
        end
    end

    initial begin
        for (cycle_count = 0; cycle_count < LIMIT; cycle_count++) @(posedge i_clk);
        $display("status: fail");
        $finish;
    end

    task automatic test_after_reset();
        send_item(MODE_TICK, tick_item(32'd0, 1'b0));
        send_item(MODE_NONE, tick_item(32'hFFFF_FFFF, 1'b1));
        send_item(MODE_SETCUR, cur_item(4'd0));
    endtask

    task automatic test_slot_extremes();
        send_item(MODE_LOAD, load_item(4'd15, ST_ZOMBIE, 1'b1, 32'hFFFF_FFFF, 8'hFF, 4'hF));
        send_item(MODE_LOAD, load_item(4'd0, ST_OTHER, 1'b0, 32'd0, 8'd0, 4'h0));
        send_item(MODE_SETCUR, cur_item(4'd15));
        send_item(MODE_NONE, load_item(4'd0, ST_RUN, 1'b1, 32'd5, 8'd3, 4'hF));
        send_item(MODE_SETCUR, cur_item(4'd0));
    endtask

    task automatic test_wake_deadlines();
        logic [31:0] now;
        now = 32'h0000_1000;
        send_item(MODE_LOAD, load_item(4'd1, ST_BLOCKED, 1'b1, 32'd0, 8'd1, F_CTX));
        send_item(MODE_LOAD, load_item(4'd2, ST_BLOCKED, 1'b1, now, 8'd1, F_CTX));
        send_item(MODE_LOAD, load_item(4'd3, ST_BLOCKED, 1'b1, now + 32'd1, 8'd1, F_CTX));
        send_item(MODE_LOAD, load_item(4'd4, ST_BLOCKED, 1'b1, now - 32'h7FFF_FFFF, 8'd1,
                                       F_CTX));
        send_item(MODE_LOAD, load_item(4'd5, ST_BLOCKED, 1'b1, now - 32'h8000_0000, 8'd1,
                                       F_CTX));
        send_item(MODE_LOAD, load_item(4'd6, ST_BLOCKED, 1'b0, now, 8'd1, F_CTX));
        send_item(MODE_TICK, tick_item(now, 1'b1));
        send_item(MODE_TICK, tick_item(now, 1'b0));
    endtask

    task automatic test_round_robin();
        set_scheduling(1'b1);
        send_item(MODE_LOAD, load_item(4'd2, ST_RUN, 1'b1, 32'd0, 8'd0, F_CTX));
        send_item(MODE_LOAD, load_item(4'd3, ST_RUN, 1'b1, 32'd0, 8'd2, F_CTX));
        send_item(MODE_LOAD, load_item(4'd4, ST_RUN, 1'b1, 32'd0, 8'd1, F_CTX | F_IDLE));
        send_item(MODE_LOAD, load_item(4'd5, ST_RUN, 1'b1, 32'd0, 8'd1, 4'h0));
        send_item(MODE_LOAD, load_item(4'd6, ST_RUN, 1'b1, 32'd0, 8'd1, F_CTX | F_OWN));
        send_item(MODE_LOAD, load_item(4'd7, ST_RUN, 1'b1, 32'd0, 8'd1,
                                       F_CTX | F_OWN | F_MGD));
        send_item(MODE_SETCUR, cur_item(4'd2));
        repeat (6) send_item(MODE_TICK, tick_item(32'd10, 1'b0));
        send_item(MODE_TICK, tick_item(32'd11, 1'b1));
        send_item(MODE_SETCUR, cur_item(4'd9));
        send_item(MODE_TICK, tick_item(32'd12, 1'b0));
    endtask

    task automatic run_random_phase(input int count, input logic en, input int ctx_pct,
                                    input logic [31:0] start_now);
        t_item       it;
        t_mode       m;
        logic [95:0] raw;
        int          r;
        set_scheduling(en);
        now_base = start_now;
        for (int n = 0; n < count; n++) begin
            raw = {$urandom(), $urandom(), $urandom()};
            it  = raw[87:0];
            it.pad = '0;
            r = $urandom_range(0, 99);
            if (r < 40) begin
                m = MODE_LOAD;
                r = $urandom_range(0, 99);
                it.slot_state    = (r < 50) ? ST_RUN : (r < 80) ? ST_BLOCKED :
                                   (r < 90) ? ST_OTHER : ST_ZOMBIE;
                it.slot_occupied = ($urandom_range(0, 9) != 0);
                r = $urandom_range(0, 9);
                if (r < 7) it.slot_wake_tick = now_base + $urandom_range(0, 12);
                else if (r < 8) it.slot_wake_tick = 32'd0;
                r = $urandom_range(0, 9);
                if (r < 6) it.slot_weight = 8'($urandom_range(0, 3));
                else if (r < 9) it.slot_weight = 8'($urandom_range(4, 20));
                it.slot_has_context = ($urandom_range(0, 99) < ctx_pct);
                it.slot_is_idle     = ($urandom_range(0, 9) == 0);
                it.slot_own_space   = ($urandom_range(0, 9) < 4);
            end else if (r < 85) begin
                m = MODE_TICK;
                if ($urandom_range(0, 99) < 3) now_base = now_base + $urandom();
                else now_base = now_base + $urandom_range(0, 3);
                it.now_tick     = now_base;
                it.preempt_held = ($urandom_range(0, 99) < 15);
            end else if (r < 97) begin
                m = MODE_SETCUR;
            end else begin
                m = MODE_NONE;
            end
            send_item(m, it);
        end
    endtask

    task automatic test_output_hold();
        rx_hold_req = 300;
        repeat (12) send_item(MODE_TICK, tick_item(now_base, 1'b0));
    endtask

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            tbl_state[i]    = ST_OTHER;
            tbl_occupied[i] = 1'b0;
            tbl_deadline[i] = '0;
            tbl_weight[i]   = '0;
            tbl_quantum[i]  = '0;
            tbl_ctx[i]      = 1'b0;
            tbl_idle[i]     = 1'b0;
            tbl_own[i]      = 1'b0;
            tbl_managed[i]  = 1'b0;
        end
        cur_slot = '0;
        sched_en = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_after_reset();
        test_slot_extremes();
        test_wake_deadlines();
        test_round_robin();
        run_random_phase(350, 1'b1, 85, $urandom());
        run_random_phase(200, 1'b0, 85, 32'd0);
        run_random_phase(300, 1'b1, 20, $urandom());
        run_random_phase(350, 1'b1, 85, 32'hFFFF_FF00);
        test_output_hold();
        run_random_phase(200, 1'b0, 60, 32'h7FFF_FFF0);
        idle_on = 1'b0;
        run_random_phase(350, 1'b1, 85, $urandom());
        drain_all();

        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
